/* src/amin_pkg.sv */
// Package for argmin_along_axis: sizes, register indexes, fp32/uint8 compare.
// No dependencies.
`default_nettype none
package amin_pkg;
   localparam int AXIS_MAX  = 4096;
   localparam int INNER_MAX = 1024;
   localparam int AXIS_W    = $clog2(AXIS_MAX);
   localparam int INNER_W   = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
   localparam int ALEN_W    = 13;
   localparam int ILEN_W    = 11;
   localparam int OLEN_W    = 16;
   localparam int IDX_W     = 12;
   localparam int VAL_W     = 32;
   localparam int CSR_W     = 16;

   typedef enum logic [1:0] {
      REG_DATA_MODE = 2'd0,
      REG_AXIS_LEN  = 2'd1,
      REG_INNER_LEN = 2'd2,
      REG_OUTER_CNT = 2'd3
   } reg_index_type;

   function automatic logic elem_less(input logic mode, input logic [31:0] a,
                                      input logic [31:0] b);
      logic nan_a, nan_b, zeros;
      logic [31:0] ka, kb;
      nan_a = a[30:0] > 31'h7F800000;
      nan_b = b[30:0] > 31'h7F800000;
      zeros = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      ka = a[31] ? ~a : {1'b1, a[30:0]};
      kb = b[31] ? ~b : {1'b1, b[30:0]};
      if (mode) elem_less = a[7:0] < b[7:0];
      else elem_less = !nan_a && !nan_b && !zeros && (ka < kb);
   endfunction
endpackage
`default_nettype wire

/* src/amin_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module amin_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/argmin_along_axis.sv */
// argmin_along_axis: running minimum per inner position along one axis.
// Throughput: one beat per cycle unless a full output register stalls input. A result
// passes stage 1 (memory read), then compare/update, into the output register.
// Same-entry read/write overlap (inner_length of 1) is covered by forwarding.
// Reset (synchronous) clears counters and pipeline valids and sets the config registers
// to defaults; memories are undefined until written by an axis-step-0 beat.
`default_nettype none
module argmin_along_axis (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // element_bits
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // min_index[11:0], zero fill
   output logic             rsp_tlast    // final_res
);
   localparam int IW = amin_pkg::INNER_W;
   localparam int AW = amin_pkg::AXIS_W;

   logic        mode_ff;
   logic [12:0] alen_ff;
   logic [10:0] ilen_ff;
   logic [15:0] olen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; alen_ff <= 13'd1; ilen_ff <= 11'd1; olen_ff <= 16'd1;
      end else if (csr_wr_en) begin
         unique case (amin_pkg::reg_index_type'(csr_index))
            amin_pkg::REG_DATA_MODE: mode_ff <= csr_wdata[0];
            amin_pkg::REG_AXIS_LEN:  alen_ff <= csr_wdata[12:0];
            amin_pkg::REG_INNER_LEN: ilen_ff <= csr_wdata[10:0];
            amin_pkg::REG_OUTER_CNT: olen_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [16:0] alen, ilen, olen;
   always_comb begin
      alen = (alen_ff == 13'd0) ? 17'd1 :
             ({4'd0, alen_ff} > 17'(amin_pkg::AXIS_MAX)) ? 17'(amin_pkg::AXIS_MAX)
             : {4'd0, alen_ff};
      ilen = (ilen_ff == 11'd0) ? 17'd1 :
             ({6'd0, ilen_ff} > 17'(amin_pkg::INNER_MAX)) ? 17'(amin_pkg::INNER_MAX)
             : {6'd0, ilen_ff};
      olen = (olen_ff == 16'd0) ? 17'd1 : {1'b0, olen_ff};
   end

   // counters
   logic [16:0] ipos_ff, apos_ff, opos_ff, ipos_in, apos_in, opos_in;
   logic [16:0] ic, ac, oc;
   logic        acc, s0_emit, s0_fin, s0_first;
   always_comb begin
      ic = (ipos_ff >= ilen) ? 17'd0 : ipos_ff;
      ac = (apos_ff >= alen) ? 17'd0 : apos_ff;
      oc = (opos_ff >= olen) ? 17'd0 : opos_ff;
      s0_first = ac == 17'd0;
      s0_emit = (ac + 17'd1) >= alen;
      s0_fin = ((ic + 17'd1) >= ilen) && ((oc + 17'd1) >= olen);
      ipos_in = ic + 17'd1; apos_in = ac; opos_in = oc;
      if (ipos_in >= ilen) begin
         ipos_in = 17'd0; apos_in = ac + 17'd1;
         if (apos_in >= alen) begin
            apos_in = 17'd0; opos_in = oc + 17'd1;
            if (opos_in >= olen) opos_in = 17'd0;
         end
      end
   end

   // stage 1: memory read in flight
   logic          s1_v_ff, s1_first_ff, s1_emit_ff, s1_fin_ff;
   logic [IW-1:0] s1_addr_ff;
   logic [AW-1:0] s1_axis_ff;
   logic [31:0]   s1_val_ff;
   // stage 2: write-back of the previous beat (for forwarding)
   logic          wb_en;
   logic [IW-1:0] wb_addr;
   logic [31:0]   wb_val;
   logic [AW-1:0] wb_idx;
   logic          fw_v_ff;
   logic [IW-1:0] fw_addr_ff;
   logic [31:0]   fw_val_ff;
   logic [AW-1:0] fw_idx_ff;

   logic [31:0]   rd_val;
   logic [AW-1:0] rd_idx;
   logic          out_v_ff, out_last_ff;
   logic [AW-1:0] out_idx_ff;

   logic s1_adv;
   assign s1_adv = !out_v_ff || rsp_tready || !s1_v_ff || !s1_emit_ff;
   assign req_tready = s1_adv;
   assign acc = req_tvalid && req_tready;

   // a stalled s1 beat re-reads its own entry so its read data holds
   logic [IW-1:0] rd_addr;
   assign rd_addr = s1_adv ? ic[IW-1:0] : s1_addr_ff;

   amin_ram #(.WIDTH(32), .DEPTH(amin_pkg::INNER_MAX)) u_val (
      .clock(clock), .wr_en(wb_en), .wr_addr(wb_addr), .wr_data(wb_val),
      .rd_addr(rd_addr), .rd_data(rd_val));
   amin_ram #(.WIDTH(AW), .DEPTH(amin_pkg::INNER_MAX)) u_idx (
      .clock(clock), .wr_en(wb_en), .wr_addr(wb_addr), .wr_data(wb_idx),
      .rd_addr(rd_addr), .rd_data(rd_idx));

   logic [31:0]   cur_val;
   logic [AW-1:0] cur_idx;
   logic          wins;
   always_comb begin
      cur_val = rd_val; cur_idx = rd_idx;
      if (fw_v_ff && fw_addr_ff == s1_addr_ff) begin
         cur_val = fw_val_ff; cur_idx = fw_idx_ff;
      end
      wins = s1_first_ff || amin_pkg::elem_less(mode_ff, s1_val_ff, cur_val);
      wb_en = s1_v_ff && s1_adv && wins;
      wb_addr = s1_addr_ff;
      wb_val = s1_val_ff;
      wb_idx = s1_axis_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipos_ff <= '0; apos_ff <= '0; opos_ff <= '0;
         s1_v_ff <= 1'b0; fw_v_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         // only a beat that emits can stall, and any write then is blocked as well
         if (acc) begin
            ipos_ff <= ipos_in; apos_ff <= apos_in; opos_ff <= opos_in;
         end
         if (s1_adv) s1_v_ff <= acc;
         fw_v_ff <= wb_en || (fw_v_ff && !(s1_v_ff && s1_adv));
         if (s1_v_ff && s1_adv && s1_emit_ff) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_first_ff <= s0_first; s1_emit_ff <= s0_emit; s1_fin_ff <= s0_fin;
         s1_addr_ff <= ic[IW-1:0]; s1_axis_ff <= ac[AW-1:0];
         s1_val_ff <= req_tdata;
      end
      if (wb_en) begin
         fw_addr_ff <= wb_addr; fw_val_ff <= wb_val; fw_idx_ff <= wb_idx;
      end
      if (s1_v_ff && s1_adv && s1_emit_ff) begin
         out_idx_ff <= wins ? s1_axis_ff : cur_idx;
         out_last_ff <= s1_fin_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {{(16-AW){1'b0}}, out_idx_ff};
   assign rsp_tlast = out_last_ff;

   a_first_load: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s1_adv && s1_first_ff) |-> wb_en)
      else $error("axis step 0 did not load entry");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready) |=> out_v_ff)
      else $error("result lost under stall");
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready && s1_v_ff && s1_emit_ff) |-> !req_tready)
      else $error("accept while result path full");
endmodule
`default_nettype wire
